[src/rrns_pkg.sv]
`timescale 1ns / 1ps

package rrns_pkg;

  localparam int unsigned MAX_COMPONENTS_DEF = 16;

  localparam int K_W   = 32;
  localparam int Z_W   = 25;
  localparam int V_W   = 31;
  localparam int IT_W  = 10;
  localparam int TOL_W = 32;

  // shared divider geometry
  localparam int DVD_W = 96;
  localparam int DVS_W = 64;
  localparam int Q_W   = 57;

  // apb register map
  localparam int ADDR_W = 3;
  localparam logic [ADDR_W-1:0] ADDR_TOL   = 3'd0;
  localparam logic [ADDR_W-1:0] ADDR_MAXIT = 3'd4;

  localparam logic [TOL_W-1:0] TOL_RST    = 32'd110;
  localparam logic [IT_W-1:0]  MAXIT_RST  = 10'd100;
  localparam logic [IT_W-1:0]  ITER_LIMIT = 10'd1000;

  typedef struct packed {
    logic store;
    logic start;
    logic eval_clr;
    logic rd;
    logic mag;
    logic mul_den;
    logic den;
    logic mul_zm;
    logic div_t;
    logic div_r;
    logic div_s;
    logic take_t;
    logic take_r;
    logic take_s;
    logic pp_clr;
    logic pp_mul;
    logic pp_add;
    logic accum;
    logic upd;
    logic out_load;
    logic conv;
    logic clr_cnt;
  } rrns_cmd_t;

  typedef struct packed {
    logic idx_end;
    logic den_zero;
    logic below_tol;
    logic j_zero;
    logic div_done;
    logic pp_last;
    logic iter_over;
  } rrns_sts_t;

endpackage

[src/rrns_div.sv]
`timescale 1ns / 1ps

module rrns_div import rrns_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic             cap_step,
  input  logic [DVD_W-1:0] dividend,
  input  logic [DVS_W-1:0] divisor,
  output logic             done,
  output logic [Q_W-1:0]   quo
);

  localparam int CNT_W = $clog2(DVD_W);
  localparam logic [DVD_W-1:0] CAP_TERM = DVD_W'(1) << 56;
  localparam logic [DVD_W-1:0] CAP_STEP = DVD_W'(1) << 32;

  logic             busy_r;
  logic             done_r;
  logic [CNT_W-1:0] cnt_r;
  logic [DVD_W-1:0] dvd_r;
  logic [DVS_W-1:0] dvs_r;
  logic [DVS_W-1:0] rem_r;
  logic [DVD_W-1:0] q_r;
  logic             cap_step_r;
  logic [DVS_W-1:0] rem_sh;
  logic [DVS_W-1:0] rem_dif;
  logic             ge;
  logic [DVD_W-1:0] cap_val;

  // restoring division, one quotient bit per cycle
  assign rem_sh  = {rem_r[DVS_W-2:0], dvd_r[DVD_W-1]};
  assign ge      = rem_sh >= dvs_r;
  assign rem_dif = rem_sh - dvs_r;
  assign cap_val = cap_step_r ? CAP_STEP : CAP_TERM;
  assign quo     = (q_r > cap_val) ? cap_val[Q_W-1:0] : q_r[Q_W-1:0];
  assign done    = done_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r     <= 1'b1;
        cnt_r      <= '0;
        dvd_r      <= dividend;
        dvs_r      <= divisor;
        rem_r      <= '0;
        q_r        <= '0;
        cap_step_r <= cap_step;
      end else if (busy_r) begin
        dvd_r <= {dvd_r[DVD_W-2:0], 1'b0};
        rem_r <= ge ? rem_dif : rem_sh;
        q_r   <= {q_r[DVD_W-2:0], ge};
        cnt_r <= cnt_r + CNT_W'(1);
        if (cnt_r == CNT_W'(DVD_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

endmodule

[src/rrns_dp.sv]
`timescale 1ns / 1ps

module rrns_dp import rrns_pkg::*; #(
  parameter int unsigned MAX_COMPONENTS = MAX_COMPONENTS_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  rrns_cmd_t        cmd,
  output rrns_sts_t        sts,
  input  logic [K_W-1:0]   in_k,
  input  logic [Z_W-1:0]   in_z,
  input  logic [V_W-1:0]   in_v0,
  input  logic [TOL_W-1:0] tol,
  input  logic [IT_W-1:0]  maxit,
  output logic [V_W-1:0]   out_vf,
  output logic [IT_W-1:0]  out_it,
  output logic             out_conv
);

  localparam int CNT_W = $clog2(MAX_COMPONENTS + 1);
  localparam int IDX_W = (MAX_COMPONENTS > 1) ? $clog2(MAX_COMPONENTS) : 1;
  localparam logic [63:0]  ONE_Q46 = 64'd1 << 46;
  localparam logic [83:0]  SAT84   = 84'd1 << 56;
  localparam logic [V_W-1:0] ONE_V = V_W'(1) << 30;

  logic [K_W+Z_W-1:0] mem [MAX_COMPONENTS];

  logic [CNT_W-1:0]  cnt_r;
  logic [CNT_W-1:0]  idx_r;
  logic [K_W-1:0]    k_r;
  logic [Z_W-1:0]    z_r;
  logic [31:0]       mag_r;
  logic              neg_r;
  logic [63:0]       prod_r;
  logic [46:0]       den_r;
  logic [Q_W-1:0]    t_r;
  logic [Q_W-1:0]    r_r;
  logic [32:0]       s_r;
  logic [113:0]      acc_r;
  logic [1:0]        pp_r;
  logic signed [63:0] f_r;
  logic [63:0]       j_r;
  logic [V_W-1:0]    v_r;
  logic [IT_W-1:0]   it_r;

  logic [31:0]       mag_nxt;
  logic [31:0]       mul_a;
  logic [31:0]       mul_b;
  logic [63:0]       mul_p;
  logic [63:0]       d46;
  logic [113:0]      addend;
  logic [83:0]       jt_full;
  logic [Q_W-1:0]    jt;
  logic [63:0]       fmag;
  logic [DVD_W-1:0]  dvd;
  logic [DVS_W-1:0]  dvs;
  logic              div_start;
  logic              div_done;
  logic [Q_W-1:0]    quo;
  logic [33:0]       v_sum;
  logic [31:0]       v_half_up;
  logic [V_W-1:0]    v_nxt;
  logic              f_pos;
  logic [IT_W-1:0]   cap;

  assign mag_nxt = (k_r < 32'h0001_0000) ? (32'h0001_0000 - k_r) : (k_r - 32'h0001_0000);

  always_comb begin
    mul_a = mag_r;
    mul_b = {1'b0, v_r};
    if (cmd.pp_mul) begin
      case (pp_r)
        2'd0: begin
          mul_a = t_r[31:0];
          mul_b = r_r[31:0];
        end
        2'd1: begin
          mul_a = t_r[31:0];
          mul_b = {7'b0, r_r[56:32]};
        end
        2'd2: begin
          mul_a = {7'b0, t_r[56:32]};
          mul_b = r_r[31:0];
        end
        default: begin
          mul_a = {7'b0, t_r[56:32]};
          mul_b = {7'b0, r_r[56:32]};
        end
      endcase
    end else if (cmd.mul_zm) begin
      mul_b = {7'b0, z_r};
    end
  end

  assign mul_p = mul_a * mul_b;
  assign d46   = neg_r ? (ONE_Q46 - prod_r) : (ONE_Q46 + prod_r);

  always_comb begin
    case (pp_r)
      2'd0:    addend = {50'b0, prod_r};
      2'd1:    addend = {18'b0, prod_r, 32'b0};
      2'd2:    addend = {18'b0, prod_r, 32'b0};
      default: addend = {prod_r[49:0], 64'b0};
    endcase
  end

  assign jt_full = acc_r[113:30];
  assign jt      = (jt_full > SAT84) ? SAT84[Q_W-1:0] : jt_full[Q_W-1:0];
  assign fmag    = f_r[63] ? (64'd0 - 64'(f_r)) : 64'(f_r);

  // divider operand selection
  assign div_start = cmd.div_t | cmd.div_r | cmd.div_s;
  always_comb begin
    if (cmd.div_s) begin
      dvd = {3'b0, fmag[62:0], 30'b0};
      dvs = j_r;
    end else if (cmd.div_r) begin
      dvd = {20'b0, mag_r, 44'b0};
      dvs = {17'b0, den_r};
    end else begin
      dvd = {9'b0, prod_r[56:0], 30'b0};
      dvs = {17'b0, den_r};
    end
  end

  rrns_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .cap_step (cmd.div_s),
    .dividend (dvd),
    .divisor  (dvs),
    .done     (div_done),
    .quo      (quo)
  );

  // newton update with halving toward the violated bound
  assign f_pos     = !f_r[63] && (f_r != 64'sd0);
  assign v_sum     = {3'b0, v_r} + {1'b0, s_r};
  assign v_half_up = ({1'b0, v_r} + {1'b0, ONE_V}) >> 1;
  always_comb begin
    if (f_pos) begin
      if (v_sum > 34'(ONE_V)) v_nxt = v_half_up[V_W-1:0];
      else v_nxt = v_sum[V_W-1:0];
    end else begin
      if (s_r > {2'b0, v_r}) v_nxt = v_r >> 1;
      else v_nxt = v_r - s_r[V_W-1:0];
    end
  end

  assign cap = (maxit > ITER_LIMIT) ? ITER_LIMIT : maxit;

  assign sts.idx_end   = idx_r == cnt_r;
  assign sts.den_zero  = den_r == 47'd0;
  assign sts.below_tol = fmag < {32'b0, tol};
  assign sts.j_zero    = j_r == 64'd0;
  assign sts.div_done  = div_done;
  assign sts.pp_last   = pp_r == 2'd3;
  assign sts.iter_over = it_r > cap;

  // component store
  always_ff @(posedge clk) begin
    if (cmd.store && (cnt_r < CNT_W'(MAX_COMPONENTS))) begin
      mem[cnt_r[IDX_W-1:0]] <= {in_k, in_z};
    end
    if (cmd.rd) begin
      {k_r, z_r} <= mem[idx_r[IDX_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      v_r   <= '0;
      it_r  <= '0;
    end else begin
      if (cmd.clr_cnt) begin
        cnt_r <= '0;
      end else if (cmd.store && (cnt_r < CNT_W'(MAX_COMPONENTS))) begin
        cnt_r <= cnt_r + CNT_W'(1);
      end
      if (cmd.start) begin
        v_r  <= (in_v0 > ONE_V) ? ONE_V : in_v0;
        it_r <= '0;
      end else if (cmd.upd) begin
        v_r  <= v_nxt;
        it_r <= it_r + IT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.eval_clr) begin
      f_r   <= '0;
      j_r   <= '0;
      idx_r <= '0;
    end else if (cmd.accum) begin
      j_r   <= j_r + {7'b0, jt};
      f_r   <= neg_r ? (f_r - $signed({7'b0, t_r})) : (f_r + $signed({7'b0, t_r}));
      idx_r <= idx_r + CNT_W'(1);
    end
    if (cmd.mag) begin
      mag_r <= mag_nxt;
      neg_r <= k_r < 32'h0001_0000;
    end
    if (cmd.mul_den || cmd.mul_zm || cmd.pp_mul) prod_r <= mul_p;
    if (cmd.den) den_r <= d46[62:16];
    if (cmd.take_t) t_r <= quo;
    if (cmd.take_r) r_r <= quo;
    if (cmd.take_s) s_r <= quo[32:0];
    if (cmd.pp_clr) begin
      acc_r <= '0;
      pp_r  <= '0;
    end else if (cmd.pp_add) begin
      acc_r <= acc_r + addend;
      pp_r  <= pp_r + 2'd1;
    end
    if (cmd.out_load) begin
      out_vf   <= v_r;
      out_it   <= it_r;
      out_conv <= cmd.conv;
    end
  end

endmodule

[src/rrns_ctrl.sv]
`timescale 1ns / 1ps

module rrns_ctrl import rrns_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  input  logic      in_last,
  output logic      in_ready,
  output logic      out_valid,
  input  logic      out_ready,
  output rrns_cmd_t cmd,
  input  rrns_sts_t sts
);

  typedef enum logic [4:0] {
    S_IDLE, S_EVC, S_RD, S_MAG, S_MULD, S_DEN, S_MULZ, S_STT, S_WT, S_STR,
    S_WR, S_PPC, S_PPM, S_PPA, S_ACC, S_TOL, S_WS, S_UPD, S_CHKI, S_FIN
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   conv_r, conv_nxt;

  assign in_ready  = state_r == S_IDLE;
  assign out_valid = out_valid_r;

  always_comb begin
    cmd           = '0;
    state_nxt     = state_r;
    conv_nxt      = conv_r;
    out_valid_nxt = out_valid_r && !out_ready;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.store = 1'b1;
          if (in_last) begin
            cmd.start = 1'b1;
            state_nxt = S_EVC;
          end
        end
      end
      S_EVC: begin
        cmd.eval_clr = 1'b1;
        state_nxt    = S_RD;
      end
      S_RD: begin
        if (sts.idx_end) begin
          state_nxt = S_TOL;
        end else begin
          cmd.rd    = 1'b1;
          state_nxt = S_MAG;
        end
      end
      S_MAG: begin
        cmd.mag   = 1'b1;
        state_nxt = S_MULD;
      end
      S_MULD: begin
        cmd.mul_den = 1'b1;
        state_nxt   = S_DEN;
      end
      S_DEN: begin
        cmd.den   = 1'b1;
        state_nxt = S_MULZ;
      end
      S_MULZ: begin
        cmd.mul_zm = 1'b1;
        if (sts.den_zero) begin
          conv_nxt  = 1'b0;
          state_nxt = S_FIN;
        end else begin
          state_nxt = S_STT;
        end
      end
      S_STT: begin
        cmd.div_t = 1'b1;
        state_nxt = S_WT;
      end
      S_WT: begin
        if (sts.div_done) begin
          cmd.take_t = 1'b1;
          state_nxt  = S_STR;
        end
      end
      S_STR: begin
        cmd.div_r = 1'b1;
        state_nxt = S_WR;
      end
      S_WR: begin
        if (sts.div_done) begin
          cmd.take_r = 1'b1;
          state_nxt  = S_PPC;
        end
      end
      S_PPC: begin
        cmd.pp_clr = 1'b1;
        state_nxt  = S_PPM;
      end
      S_PPM: begin
        cmd.pp_mul = 1'b1;
        state_nxt  = S_PPA;
      end
      S_PPA: begin
        cmd.pp_add = 1'b1;
        state_nxt  = sts.pp_last ? S_ACC : S_PPM;
      end
      S_ACC: begin
        cmd.accum = 1'b1;
        state_nxt = S_RD;
      end
      S_TOL: begin
        if (sts.below_tol) begin
          conv_nxt  = 1'b1;
          state_nxt = S_FIN;
        end else if (sts.j_zero) begin
          conv_nxt  = 1'b0;
          state_nxt = S_FIN;
        end else begin
          cmd.div_s = 1'b1;
          state_nxt = S_WS;
        end
      end
      S_WS: begin
        if (sts.div_done) begin
          cmd.take_s = 1'b1;
          state_nxt  = S_UPD;
        end
      end
      S_UPD: begin
        cmd.upd   = 1'b1;
        state_nxt = S_CHKI;
      end
      S_CHKI: begin
        if (sts.iter_over) begin
          conv_nxt  = 1'b0;
          state_nxt = S_FIN;
        end else begin
          state_nxt = S_EVC;
        end
      end
      S_FIN: begin
        cmd.conv = conv_r;
        if (!out_valid_r || out_ready) begin
          cmd.out_load  = 1'b1;
          cmd.clr_cnt   = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      conv_r      <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      conv_r      <= conv_nxt;
    end
  end

endmodule

[src/rachford_rice_newton_solver_unit.sv]
`timescale 1ns / 1ps

// rachford-rice vapour fraction solver, newton iteration in fixed point
// input channel (in_valid/in_ready): one component per transfer, k value in
//   unsigned q16.16 and feed fraction in q1.24; a transfer with
//   in_last_component set also carries the start fraction (q1.30) and starts
//   the solve; components beyond the store depth are dropped
// result channel (out_valid/out_ready): one transfer per solve with the
//   vapour fraction, the count of newton updates and the converged flag
// config: apb-style port, residual tolerance at 0x0, iteration cap at 0x4
// a plain component transfer is taken whenever the unit is idle; during a
//   solve the iteration time is set by the single shared bit-serial
//   divider (two divisions per component, one for the step)
// the input stays ready while a finished result waits; a new solve that ends
//   while the receiver stalls holds in its final state until the output
//   register frees up
// reset clears the component count, the estimate, the iteration count, the
//   output valid and restores the register defaults

module rachford_rice_newton_solver_unit import rrns_pkg::*; #(
  parameter int unsigned MAX_COMPONENTS = MAX_COMPONENTS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  // component transfers
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [K_W-1:0]    in_k_value,
  input  logic [Z_W-1:0]    in_feed_fraction,
  input  logic [V_W-1:0]    in_initial_vapour_fraction,
  input  logic              in_last_component,
  // result transfers
  output logic              out_valid,
  input  logic              out_ready,
  output logic [V_W-1:0]    out_vapour_fraction,
  output logic [IT_W-1:0]   out_iterations_used,
  output logic              out_converged,
  // register port
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  logic [TOL_W-1:0] tol_r;
  logic [IT_W-1:0]  maxit_r;
  logic             cfg_wr;
  rrns_cmd_t        cmd;
  rrns_sts_t        sts;

  // register writes complete in the access phase
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tol_r   <= TOL_RST;
      maxit_r <= MAXIT_RST;
    end else if (cfg_wr) begin
      case (paddr)
        ADDR_TOL:   tol_r   <= pwdata;
        ADDR_MAXIT: maxit_r <= pwdata[IT_W-1:0];
        default:    ;
      endcase
    end
  end

  always_comb begin
    case (paddr)
      ADDR_TOL:   prdata = tol_r;
      ADDR_MAXIT: prdata = {{(32-IT_W){1'b0}}, maxit_r};
      default:    prdata = '0;
    endcase
  end

  // sequencer: walks components, divisions and the update
  rrns_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_last   (in_last_component),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd),
    .sts       (sts)
  );

  // component store, multiplier, shared divider and accumulators
  rrns_dp #(
    .MAX_COMPONENTS (MAX_COMPONENTS)
  ) u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .sts      (sts),
    .in_k     (in_k_value),
    .in_z     (in_feed_fraction),
    .in_v0    (in_initial_vapour_fraction),
    .tol      (tol_r),
    .maxit    (maxit_r),
    .out_vf   (out_vapour_fraction),
    .out_it   (out_iterations_used),
    .out_conv (out_converged)
  );

endmodule

[src/rrns_chk.sv]
`timescale 1ns / 1ps

module rrns_chk import rrns_pkg::*; (
  input logic            clk,
  input logic            rst_n,
  input logic            out_valid,
  input logic            out_ready,
  input logic [V_W-1:0]  out_vapour_fraction,
  input logic [IT_W-1:0] out_iterations_used,
  input logic            out_converged
);

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_vapour_fraction)
      && $stable(out_iterations_used) && $stable(out_converged))
    else $error("result changed while stalled");

  a_vf_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_vapour_fraction <= 31'h4000_0000)
    else $error("vapour fraction above one");

  a_it_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_iterations_used <= 10'd1001)
    else $error("iteration count above limit");

  a_rst: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind rachford_rice_newton_solver_unit rrns_chk u_chk (.*);

[sim/tb_rachford_rice_newton_solver_unit.sv]
`timescale 1ns / 1ps

module tb_rachford_rice_newton_solver_unit;
  import rrns_pkg::*;

  localparam longint unsigned ONE_V = 64'd1 << 30;

  typedef struct {
    logic [K_W-1:0]   k;
    logic [Z_W-1:0]   z;
    logic [V_W-1:0]   v;
    bit               last;
    bit               set_cfg;
    logic [TOL_W-1:0] tol;
    logic [IT_W-1:0]  cap;
    bit               typed;
    logic [V_W-1:0]   ev;
    logic [IT_W-1:0]  eit;
    bit               econv;
  } stim_row_t;

  typedef struct {
    logic [V_W-1:0]  vf;
    logic [IT_W-1:0] iters;
    bit              conv;
  } flash_result_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_ready;
  logic [K_W-1:0]    in_k_value = '0;
  logic [Z_W-1:0]    in_feed_fraction = '0;
  logic [V_W-1:0]    in_initial_vapour_fraction = '0;
  logic              in_last_component = 1'b0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic [V_W-1:0]    out_vapour_fraction;
  logic [IT_W-1:0]   out_iterations_used;
  logic              out_converged;
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [31:0]       pwdata = '0;
  logic [31:0]       prdata;
  logic              pready;

  // typed expectation riding along with the held input transfer
  bit              cur_typed = 1'b0;
  flash_result_t   cur_exp;

  // predictor state
  logic [K_W-1:0]   ratio_mem[MAX_COMPONENTS_DEF];
  logic [Z_W-1:0]   feed_mem[MAX_COMPONENTS_DEF];
  int unsigned      comp_n = 0;
  logic [TOL_W-1:0] tol_reg = TOL_RST;
  logic [IT_W-1:0]  maxit_reg = MAXIT_RST;

  flash_result_t pending_results[$];
  stim_row_t     stim_table[$];
  int            fail_count = 0;

  rachford_rice_newton_solver_unit dut (.*);

  always #2 clk = ~clk;

  // floor(num / den) clipped at lim
  function automatic logic [127:0] sat_div(input logic [127:0] num, input logic [127:0] den,
                                           input logic [127:0] lim);
    logic [127:0] q;
    q = num / den;
    return (q > lim) ? lim : q;
  endfunction

  // newton solve over the stored components, same fixed point as the block
  function automatic flash_result_t solve_flash(input logic [V_W-1:0] v_start);
    flash_result_t    res;
    longint unsigned  v;
    longint           f;
    longint           d46;
    longint unsigned  jsum;
    longint unsigned  fmag;
    logic [127:0]     mag, t, r, den, step;
    int unsigned      n_upd;
    int unsigned      lim_it;
    bit               neg, ok;
    v = (v_start > ONE_V) ? ONE_V : v_start;
    n_upd = 0;
    res.conv = 1'b0;
    lim_it = (maxit_reg > ITER_LIMIT) ? ITER_LIMIT : maxit_reg;
    while (1) begin
      f = 0;
      jsum = 0;
      ok = 1'b1;
      for (int i = 0; i < comp_n; i++) begin
        neg = ratio_mem[i] < 32'h10000;
        mag = neg ? 128'(32'h10000 - ratio_mem[i]) : 128'(ratio_mem[i] - 32'h10000);
        d46 = (64'sd1 <<< 46) + (neg ? -longint'(mag) : longint'(mag)) * longint'(v);
        den = 128'(d46 >>> 16);
        if (den == 0) begin
          ok = 1'b0;
          break;
        end
        t = sat_div((128'(feed_mem[i]) * mag) << 30, den, 128'd1 << 56);
        r = sat_div(mag << 44, den, 128'd1 << 56);
        jsum += 64'(((t * r) >> 30) > (128'd1 << 56) ? (128'd1 << 56) : ((t * r) >> 30));
        f += neg ? -longint'(t) : longint'(t);
      end
      if (!ok) break;
      fmag = (f < 0) ? -f : f;
      if (fmag < tol_reg) begin
        res.conv = 1'b1;
        break;
      end
      if (jsum == 0) break;
      step = sat_div(128'(fmag) << 30, 128'(jsum), 128'd1 << 32);
      if (f > 0) begin
        if (128'(v) + step > ONE_V) v = (ONE_V + v) >> 1;
        else v = v + 64'(step);
      end else begin
        if (step > v) v = v >> 1;
        else v = v - 64'(step);
      end
      n_upd++;
      if (n_upd > lim_it) break;
    end
    res.vf = V_W'(v);
    res.iters = IT_W'(n_upd);
    return res;
  endfunction

  // input side monitor: store the component; on the last one, solve or take the typed expectation
  always @(posedge clk) begin
    if (rst_n && in_valid && in_ready) begin
      if (comp_n < MAX_COMPONENTS_DEF) begin
        ratio_mem[comp_n] = in_k_value;
        feed_mem[comp_n] = in_feed_fraction;
        comp_n++;
      end
      if (in_last_component) begin
        if (cur_typed) pending_results.push_back(cur_exp);
        else pending_results.push_back(solve_flash(in_initial_vapour_fraction));
        comp_n = 0;
      end
    end
  end

  // result side monitor
  always @(posedge clk) begin
    flash_result_t exp_r;
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result transfer vf=%h it=%0d conv=%b", $time,
                 out_vapour_fraction, out_iterations_used, out_converged);
        fail_count++;
      end else begin
        exp_r = pending_results.pop_front();
        if (out_vapour_fraction !== exp_r.vf) begin
          $display("%0t: vapour_fraction expected %h actual %h", $time, exp_r.vf,
                   out_vapour_fraction);
          fail_count++;
        end
        if (out_iterations_used !== exp_r.iters) begin
          $display("%0t: iterations_used expected %0d actual %0d", $time, exp_r.iters,
                   out_iterations_used);
          fail_count++;
        end
        if (out_converged !== exp_r.conv) begin
          $display("%0t: converged expected %b actual %b", $time, exp_r.conv, out_converged);
          fail_count++;
        end
      end
    end
  end

  // receiver with random stalls
  initial begin
    int w;
    @(posedge clk iff rst_n);
    forever begin
      w = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 4);
      if (w > 0) begin
        out_ready <= 1'b0;
        repeat (w) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!(out_valid && out_ready));
    end
  end

  task automatic reg_write(input logic [ADDR_W-1:0] addr, input logic [31:0] data);
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= addr;
    pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
  endtask

  // drain all results and pause, then load both registers
  task automatic set_config(input logic [TOL_W-1:0] tol, input logic [IT_W-1:0] cap);
    in_valid <= 1'b0;
    repeat (2) @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    reg_write(ADDR_TOL, tol);
    reg_write(ADDR_MAXIT, 32'(cap));
    tol_reg = tol;
    maxit_reg = cap;
  endtask

  // one component transfer, gap drawn before it
  task automatic send_component(input stim_row_t row, input int gap);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_k_value <= row.k;
    in_feed_fraction <= row.z;
    in_initial_vapour_fraction <= row.v;
    in_last_component <= row.last;
    cur_typed <= row.typed;
    cur_exp <= '{row.ev, row.eit, row.econv};
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic add_row(input logic [K_W-1:0] k, input logic [Z_W-1:0] z,
                         input logic [V_W-1:0] v, input bit last, input bit typed,
                         input logic [V_W-1:0] ev, input logic [IT_W-1:0] eit,
                         input bit econv);
    stim_row_t row;
    row = '{k, z, v, last, 1'b0, '0, '0, typed, ev, eit, econv};
    stim_table.push_back(row);
  endtask

  task automatic cfg_row(input logic [TOL_W-1:0] tol, input logic [IT_W-1:0] cap);
    stim_table[$].set_cfg = 1'b1;
    stim_table[$].tol = tol;
    stim_table[$].cap = cap;
  endtask

  initial begin
    stim_row_t row;
    int        items;
    int        n_comp;
    int        phase;
    int        kmode;
    bit        calm;
    logic [TOL_W-1:0] ptol;

    // directed table
    // zero denominator at the upper bound with k of zero
    add_row(32'h0, 25'h1000000, 31'h40000000, 1, 1, 31'h40000000, 10'd0, 0);
    cfg_row(TOL_RST, MAXIT_RST);
    // start above one is clamped, then the denominator is zero
    add_row(32'h0, 25'h0, 31'h7FFFFFFF, 1, 1, 31'h40000000, 10'd0, 0);
    // zero feed means zero residual, converged at once
    add_row(32'hFFFFFFFF, 25'h0, 31'h0, 1, 1, 31'h0, 10'd0, 1);
    // ordinary two and three component solves
    add_row(32'h00020000, 25'h0800000, 31'h0, 0, 0, '0, '0, 0);
    add_row(32'h00008000, 25'h0800000, 31'h20000000, 1, 0, '0, '0, 0);
    add_row(32'h00010000, 25'h1000000, 31'h1, 0, 0, '0, '0, 0);
    add_row(32'h01FFFFFF, 25'h0000001, 31'h0, 0, 0, '0, '0, 0);
    add_row(32'h00000100, 25'h0FFFFFF, 31'h40000000, 1, 0, '0, '0, 0);
    // zero derivative with a zero tolerance
    add_row(32'h00010001, 25'h1, 31'h0, 1, 1, 31'h0, 10'd0, 0);
    cfg_row(32'h0, 10'd1000);
    // never converges, cap above the limit acts as the limit
    add_row(32'h00020000, 25'h1000000, 31'h0, 1, 1, 31'h40000000, 10'd1001, 0);
    cfg_row(32'h0, 10'd1023);
    // store full: the seventeenth component is dropped but starts the solve
    for (int i = 0; i < 16; i++) begin
      add_row(32'h00004000 + 32'(i) * 32'h3000, 25'h0100000 + 25'(i), 31'h0, 0, 0,
              '0, '0, 0);
      if (i == 0) cfg_row(TOL_RST, 10'd1);
    end
    add_row(32'hFFFFFFFF, 25'h1000000, 31'h10000000, 1, 0, '0, '0, 0);

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (stim_table[i]) begin
      if (stim_table[i].set_cfg) set_config(stim_table[i].tol, stim_table[i].cap);
      send_component(stim_table[i], $urandom_range(0, 4));
    end

    // random solves over several register settings
    items = 0;
    phase = 0;
    while (items < 1250) begin
      case (phase % 4)
        0: ptol = 32'h0;
        1: ptol = 32'hFFFFFFFF;
        2: ptol = TOL_RST;
        default: ptol = $urandom;
      endcase
      set_config(ptol, (phase == 0) ? 10'd1 : IT_W'($urandom_range(1, 8)));
      calm = phase[0];
      for (int s = 0; s < 150 && items < 1250; s += n_comp) begin
        n_comp = ($urandom_range(0, 19) == 0) ? $urandom_range(15, 19)
                                               : $urandom_range(1, 5);
        for (int c = 0; c < n_comp; c++) begin
          kmode = $urandom_range(0, 2);
          row.k = (kmode == 0) ? $urandom :
                  (kmode == 1) ? 32'($urandom_range(32'h10000, 32'h80000))
                               : 32'($urandom_range(0, 32'hFFFF));
          row.z = ($urandom_range(0, 9) == 0) ? 25'h1000000 : Z_W'($urandom & 32'hFFFFFF);
          row.v = ($urandom_range(0, 7) == 0) ? V_W'($urandom)
                                               : V_W'($urandom_range(0, 32'h40000000));
          row.last = (c == n_comp - 1);
          row.typed = 1'b0;
          send_component(row, calm ? 0 : $urandom_range(0, 4));
          items++;
        end
      end
      phase++;
    end

    in_valid <= 1'b0;
    repeat (2) @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (fail_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin
    #200ms;
    $display("TB_ERROR");
    $finish;
  end

endmodule

[rachford_rice_newton_solver_unit.f]
src/rrns_pkg.sv
src/rrns_div.sv
src/rrns_dp.sv
src/rrns_ctrl.sv
src/rachford_rice_newton_solver_unit.sv
src/rrns_chk.sv
sim/tb_rachford_rice_newton_solver_unit.sv
